FILE: hdl/smvm_pkg.sv
// ----------------------------------------------------------------------------
// smvm_pkg
// shared types and constants of the symmetric matrix-vector multiply block
// ----------------------------------------------------------------------------
package smvm_pkg;

    localparam int DATA_W        = 32;
    localparam int Q_FRAC        = 16;
    localparam int MAX_ORDER_DEF = 16;
    localparam int SIZE_W        = 5;
    localparam int FIELD_W       = 4;
    localparam logic signed [DATA_W-1:0] ONE = 32'sh0001_0000;

    typedef enum logic [1:0] {
        ACT_MAT     = 2'd0,
        ACT_X       = 2'd1,
        ACT_Y       = 2'd2,
        ACT_COMPUTE = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        CFG_SIZE  = 2'd0,
        CFG_UPPER = 2'd1,
        CFG_ALPHA = 2'd2,
        CFG_BETA  = 2'd3
    } cfg_idx_t;

    // control that travels with a row through the chain
    typedef struct packed {
        logic valid;
        logic last;
    } tok_t;

endpackage

FILE: hdl/smvm_cell.sv
// ----------------------------------------------------------------------------
// smvm_cell
// one column of the chain: holds x[j], column j and row j of the matrix
// ----------------------------------------------------------------------------
module smvm_cell
    import smvm_pkg::*;
#(
    parameter int MAX_ORDER = MAX_ORDER_DEF,
    parameter int IDX       = 0,
    parameter int DOT_W     = 53
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              adv,
    input  logic                              use_upper,
    input  logic [$clog2(MAX_ORDER+1)-1:0]    n_cur,
    // load port
    input  logic                              ld_mat,
    input  logic                              ld_x,
    input  logic [((MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1)-1:0] ld_row,
    input  logic [((MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1)-1:0] ld_col,
    input  logic signed [DATA_W-1:0]          ld_value,
    // chain in
    input  tok_t                              in_tok,
    input  logic [((MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1)-1:0] in_row,
    input  logic signed [DOT_W-1:0]           in_sum,
    // chain out
    output tok_t                              out_tok,
    output logic [((MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1)-1:0] out_row,
    output logic signed [DOT_W-1:0]           out_sum
);

    localparam int ADDR_W = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int PROD_W = 2 * DATA_W;
    localparam int TERM_W = PROD_W - Q_FRAC;

    logic signed [DATA_W-1:0] colmem [MAX_ORDER];
    logic signed [DATA_W-1:0] rowmem [MAX_ORDER];
    logic signed [DATA_W-1:0] x_reg;

    logic signed [DATA_W-1:0] col_rd_reg, row_rd_reg;
    logic                     swap_reg;
    tok_t                     s1_tok_reg, s2_tok_reg, s3_tok_reg;
    logic [ADDR_W-1:0]        s1_row_reg, s2_row_reg, s3_row_reg;
    logic signed [DOT_W-1:0]  s1_sum_reg, s2_sum_reg, s3_sum_reg;
    logic signed [PROD_W-1:0] prod_reg;

    logic                     swap;
    logic                     active;
    logic signed [DATA_W-1:0] entry;
    logic signed [DOT_W-1:0]  term;

    // mirrored entry lives in this cell's row copy
    assign swap   = use_upper ? (int'(in_row) > IDX) : (int'(in_row) < IDX);
    assign active = int'(n_cur) > IDX;
    assign entry  = swap_reg ? row_rd_reg : col_rd_reg;
    assign term   = active ? {{(DOT_W-TERM_W){prod_reg[PROD_W-1]}}, prod_reg[PROD_W-1:Q_FRAC]}
                           : '0;

    always_ff @(posedge clk)
    begin
        if (ld_mat && (int'(ld_col) == IDX))
        begin
            colmem[ld_row] <= ld_value;
        end
        if (ld_mat && (int'(ld_row) == IDX))
        begin
            rowmem[ld_col] <= ld_value;
        end
        if (ld_x && (int'(ld_row) == IDX))
        begin
            x_reg <= ld_value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            col_rd_reg <= colmem[in_row];
            row_rd_reg <= rowmem[in_row];
            swap_reg   <= swap;
            s1_row_reg <= in_row;
            s1_sum_reg <= in_sum;
            prod_reg   <= entry * x_reg;
            s2_row_reg <= s1_row_reg;
            s2_sum_reg <= s1_sum_reg;
            s3_row_reg <= s2_row_reg;
            s3_sum_reg <= s2_sum_reg + term;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_tok_reg <= '0;
            s2_tok_reg <= '0;
            s3_tok_reg <= '0;
        end
        else if (adv)
        begin
            s1_tok_reg <= in_tok;
            s2_tok_reg <= s1_tok_reg;
            s3_tok_reg <= s2_tok_reg;
        end
    end

    assign out_tok = s3_tok_reg;
    assign out_row = s3_row_reg;
    assign out_sum = s3_sum_reg;

endmodule

FILE: hdl/smvm_fin.sv
// ----------------------------------------------------------------------------
// smvm_fin
// final scaling: beta*y + alpha*dot, saturation, y store and output register
// ----------------------------------------------------------------------------
module smvm_fin
    import smvm_pkg::*;
#(
    parameter int MAX_ORDER = MAX_ORDER_DEF,
    parameter int DOT_W     = 53
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              adv,
    input  logic signed [DATA_W-1:0]          alpha_gain,
    input  logic signed [DATA_W-1:0]          beta_gain,
    input  logic                              ld_y,
    input  logic [((MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1)-1:0] ld_row,
    input  logic signed [DATA_W-1:0]          ld_value,
    input  tok_t                              in_tok,
    input  logic [((MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1)-1:0] in_row,
    input  logic signed [DOT_W-1:0]           in_sum,
    output tok_t                              out_tok,
    output logic [((MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1)-1:0] out_row,
    output logic signed [DATA_W-1:0]          out_result,
    output logic                              out_sat
);

    localparam int ADDR_W = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int DC_W   = DATA_W + 1;
    localparam int PB_W   = 2 * DATA_W;
    localparam int PA_W   = DATA_W + DC_W;
    localparam int T_W    = PA_W - Q_FRAC + 1;
    localparam logic signed [DOT_W-1:0] LIM_HI = DOT_W'(64'h0000_0000_FFFF_FFFF);
    localparam logic signed [DOT_W-1:0] LIM_LO = -LIM_HI;
    localparam logic signed [T_W-1:0]   SAT_HI = T_W'(64'sh0000_0000_7FFF_FFFF);
    localparam logic signed [T_W-1:0]   SAT_LO = -SAT_HI - T_W'(1);

    logic signed [DATA_W-1:0] ymem [MAX_ORDER];

    tok_t                     f1_tok_reg, f2_tok_reg, out_tok_reg;
    logic [ADDR_W-1:0]        f1_row_reg, f2_row_reg, out_row_reg;
    logic signed [DATA_W-1:0] y_rd_reg;
    logic signed [DC_W-1:0]   dotc_reg;
    logic signed [PB_W-1:0]   pb_reg;
    logic signed [PA_W-1:0]   pa_reg;
    logic signed [DATA_W-1:0] result_reg;
    logic                     sat_reg;

    logic signed [DC_W-1:0]   dotc;
    logic signed [T_W-1:0]    total;
    logic signed [DATA_W-1:0] fresh;
    logic                     clip;

    // product scale takes the magnitude of the sum clipped below 2^32
    always_comb
    begin
        priority if (in_sum > LIM_HI)
            dotc = DC_W'(LIM_HI);
        else if (in_sum < LIM_LO)
            dotc = DC_W'(LIM_LO);
        else
            dotc = DC_W'(in_sum);
    end

    always_comb
    begin
        total = {{(T_W-(PB_W-Q_FRAC)){pb_reg[PB_W-1]}}, pb_reg[PB_W-1:Q_FRAC]}
              + {{(T_W-(PA_W-Q_FRAC)){pa_reg[PA_W-1]}}, pa_reg[PA_W-1:Q_FRAC]};
        clip  = 1'b1;
        priority if (total > SAT_HI)
            fresh = DATA_W'(SAT_HI);
        else if (total < SAT_LO)
            fresh = DATA_W'(SAT_LO);
        else
        begin
            fresh = DATA_W'(total);
            clip  = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld_y)
        begin
            ymem[ld_row] <= ld_value;
        end
        else if (adv && f2_tok_reg.valid)
        begin
            ymem[f2_row_reg] <= fresh;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            y_rd_reg    <= ymem[in_row];
            dotc_reg    <= dotc;
            f1_row_reg  <= in_row;
            pb_reg      <= beta_gain * y_rd_reg;
            pa_reg      <= alpha_gain * dotc_reg;
            f2_row_reg  <= f1_row_reg;
            out_row_reg <= f2_row_reg;
            result_reg  <= fresh;
            sat_reg     <= clip;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_tok_reg  <= '0;
            f2_tok_reg  <= '0;
            out_tok_reg <= '0;
        end
        else if (adv)
        begin
            f1_tok_reg  <= in_tok;
            f2_tok_reg  <= f1_tok_reg;
            out_tok_reg <= f2_tok_reg;
        end
    end

    assign out_tok    = out_tok_reg;
    assign out_row    = out_row_reg;
    assign out_result = result_reg;
    assign out_sat    = sat_reg;

endmodule

FILE: hdl/symmetric_matrix_vector_multiply_top.sv
// ----------------------------------------------------------------------------
// symmetric_matrix_vector_multiply_top
// y := beta*y + alpha*A*x on a symmetric matrix, one triangle stored
// ----------------------------------------------------------------------------
// flow: after a compute request the rows enter the cell chain, and the results
//   come out one per cycle while m_tready does not stall the pipeline
// occupancy: a compute holds the input closed until its last result is taken,
//   set by the depth of the cell chain (three stages per cell)
// reset: registers return to n = 1, lower triangle, alpha = beta = 1.0;
//   matrix, x and y stores hold no value until loaded
module symmetric_matrix_vector_multiply_top
    import smvm_pkg::*;
#(
    parameter int MAX_ORDER = MAX_ORDER_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    // request stream: tdata = row[3:0], col[7:4], value[39:8]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,
    input  logic [1:0]  s_tuser,    // action[1:0]
    // result stream: tdata = index[3:0], result[35:4], zero pad[39:36]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,
    output logic        m_tlast,
    output logic [0:0]  m_tuser,    // saturated[0]
    // register writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int ADDR_W = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int CNT_W  = $clog2(MAX_ORDER + 1);
    localparam int DOT_W  = 2 * DATA_W - Q_FRAC + $clog2(MAX_ORDER) + 1;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    // configuration registers
    logic [SIZE_W-1:0]        size_reg;
    logic                     upper_reg;
    logic signed [DATA_W-1:0] alpha_reg;
    logic signed [DATA_W-1:0] beta_reg;

    // sequencer
    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [CNT_W-1:0]  issue_reg, issue_next;
    logic              issuing_reg, issuing_next;

    // request fields
    action_t                  action;
    logic [FIELD_W-1:0]       row_f, col_f;
    logic signed [DATA_W-1:0] value_f;
    logic                     accept, row_ok, col_ok;
    logic                     ld_mat, ld_x, ld_y;
    logic [ADDR_W-1:0]        ld_row, ld_col;
    logic [CNT_W-1:0]         n_clamp;
    logic                     issue_last;

    // chain
    logic  adv;
    tok_t  chain_tok [MAX_ORDER+1];
    logic [ADDR_W-1:0]        chain_row [MAX_ORDER+1];
    logic signed [DOT_W-1:0]  chain_sum [MAX_ORDER+1];

    tok_t                     fin_tok;
    logic [ADDR_W-1:0]        fin_row;
    logic signed [DATA_W-1:0] fin_result;
    logic                     fin_sat;

    assign action  = action_t'(s_tuser);
    assign row_f   = s_tdata[3:0];
    assign col_f   = s_tdata[7:4];
    assign value_f = s_tdata[39:8];

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;

    // loads beyond the store are dropped
    assign row_ok = int'(row_f) < MAX_ORDER;
    assign col_ok = int'(col_f) < MAX_ORDER;
    assign ld_row = ADDR_W'(row_f);
    assign ld_col = ADDR_W'(col_f);
    assign ld_mat = accept && (action == ACT_MAT) && row_ok && col_ok;
    assign ld_x   = accept && (action == ACT_X) && row_ok;
    assign ld_y   = accept && (action == ACT_Y) && row_ok;

    // order 0 acts as 1, above the store acts as full size
    always_comb
    begin
        priority if (size_reg == '0)
            n_clamp = CNT_W'(1);
        else if (int'(size_reg) > MAX_ORDER)
            n_clamp = CNT_W'(MAX_ORDER);
        else
            n_clamp = CNT_W'(size_reg);
    end

    // the whole pipeline moves together, held only by a waiting result
    assign adv = !m_tvalid || m_tready;

    assign issue_last = ({1'b0, issue_reg} + 1'b1) == {1'b0, n_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg  <= SIZE_W'(1);
            upper_reg <= 1'b0;
            alpha_reg <= ONE;
            beta_reg  <= ONE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_SIZE:  size_reg  <= cfg_data[SIZE_W-1:0];
                CFG_UPPER: upper_reg <= cfg_data[0];
                CFG_ALPHA: alpha_reg <= cfg_data;
                CFG_BETA:  beta_reg  <= cfg_data;
                default:   size_reg  <= size_reg;
            endcase
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        n_next       = n_reg;
        issue_next   = issue_reg;
        issuing_next = issuing_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (action == ACT_COMPUTE))
                begin
                    state_next   = ST_RUN;
                    n_next       = n_clamp;
                    issue_next   = '0;
                    issuing_next = 1'b1;
                end
            end
            ST_RUN:
            begin
                if (adv && issuing_reg)
                begin
                    issue_next = issue_reg + 1'b1;
                    if (issue_last)
                    begin
                        issuing_next = 1'b0;
                    end
                end
                if (m_tvalid && m_tready && m_tlast)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            n_reg       <= CNT_W'(1);
            issue_reg   <= '0;
            issuing_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            n_reg       <= n_next;
            issue_reg   <= issue_next;
            issuing_reg <= issuing_next;
        end
    end

    // rows enter the head of the chain with an empty partial sum
    assign chain_tok[0].valid = issuing_reg;
    assign chain_tok[0].last  = issue_last;
    assign chain_row[0]       = ADDR_W'(issue_reg);
    assign chain_sum[0]       = '0;

    for (genvar j = 0; j < MAX_ORDER; j++)
    begin : g_cell
        smvm_cell #(
            .MAX_ORDER (MAX_ORDER),
            .IDX       (j),
            .DOT_W     (DOT_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .use_upper (upper_reg),
            .n_cur     (n_reg),
            .ld_mat    (ld_mat),
            .ld_x      (ld_x),
            .ld_row    (ld_row),
            .ld_col    (ld_col),
            .ld_value  (value_f),
            .in_tok    (chain_tok[j]),
            .in_row    (chain_row[j]),
            .in_sum    (chain_sum[j]),
            .out_tok   (chain_tok[j+1]),
            .out_row   (chain_row[j+1]),
            .out_sum   (chain_sum[j+1])
        );
    end

    // scaling, saturation and the y store; its last stage is the output register
    smvm_fin #(
        .MAX_ORDER (MAX_ORDER),
        .DOT_W     (DOT_W)
    ) u_fin (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .alpha_gain (alpha_reg),
        .beta_gain  (beta_reg),
        .ld_y       (ld_y),
        .ld_row     (ld_row),
        .ld_value   (value_f),
        .in_tok     (chain_tok[MAX_ORDER]),
        .in_row     (chain_row[MAX_ORDER]),
        .in_sum     (chain_sum[MAX_ORDER]),
        .out_tok    (fin_tok),
        .out_row    (fin_row),
        .out_result (fin_result),
        .out_sat    (fin_sat)
    );

    assign m_tvalid = fin_tok.valid;
    assign m_tlast  = fin_tok.last;
    assign m_tdata  = {4'd0, fin_result, FIELD_W'(fin_row)};
    assign m_tuser  = fin_sat;

endmodule

FILE: hdl/smvm_chk.sv
// ----------------------------------------------------------------------------
// smvm_chk
// port-level checks of the symmetric matrix-vector multiply block
// ----------------------------------------------------------------------------
module smvm_chk
    import smvm_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        m_tlast
);

    // no requests are taken while results are pending
    a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready)
        else $error("request taken while results pending");

    // a compute request closes the input
    a_compute_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser == ACT_COMPUTE)) |=> !s_tready)
        else $error("input open after compute request");

    // the final result reopens the input
    a_reopen: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> (s_tready && !m_tvalid))
        else $error("input not reopened after last result");

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("stalled result changed");

endmodule

bind symmetric_matrix_vector_multiply_top smvm_chk u_smvm_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

FILE: sim/tb_symmetric_matrix_vector_multiply_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_symmetric_matrix_vector_multiply_top
// self-checking bench for the symmetric matrix-vector multiply block
// ----------------------------------------------------------------------------
// A short table of directed requests (order 1, extreme values, saturation both
// ways) runs first. Random load/compute sequences follow under changing
// register settings. Every compute is predicted here in Q16.16 with floor
// rounding and saturation, and the results are checked field by field, in
// order. The sender works in bursts and the result side stalls in a pattern.
// ----------------------------------------------------------------------------
module tb_symmetric_matrix_vector_multiply_top;
    import smvm_pkg::*;

    localparam int     ORDER       = 16;
    localparam int     DRAIN_WAIT  = 3 * ORDER + 12;   // compute latency plus margin
    localparam int     RANDOM_REQS = 200;
    localparam longint CYCLE_LIMIT = 400000;
    localparam longint WIDE_CAP    = 64'sd1 <<< 62;
    localparam longint DOT_CAP     = 64'sh0000_0000_FFFF_FFFF;

    // one result the block owes us
    typedef struct {
        logic [3:0]  index;
        logic [31:0] result;
        bit          last;
        bit          sat;
    } y_entry_t;

    // one row of the directed table; chk means the result is typed in
    typedef struct {
        action_t     act;
        logic [3:0]  row;
        logic [3:0]  col;
        logic [31:0] value;
        bit          chk;
        logic [31:0] exp_result;
        bit          exp_sat;
    } directed_req_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        m_tlast;
    logic [0:0]  m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    symmetric_matrix_vector_multiply_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // shadow of the block: registers and stores, with written marks
    logic [4:0]         order_reg;
    bit                 upper_reg;
    logic signed [31:0] alpha_reg;
    logic signed [31:0] beta_reg;
    logic signed [31:0] mat_mem [ORDER*ORDER];
    logic signed [31:0] x_mem [ORDER];
    logic signed [31:0] y_mem [ORDER];
    bit                 mat_set [ORDER*ORDER];
    bit                 x_set [ORDER];
    bit                 y_set [ORDER];

    y_entry_t pending_y [$];
    int       errors;
    int       results_seen;
    int       saturated_seen;
    int       computes_sent;
    int       loads_sent;
    int       burst_left;
    longint   cycles;

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // run guard
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // result side stall pattern: free running, random, or mostly stalled
    int stall_mode;
    int stall_phase;
    always @(posedge clk)
    begin
        stall_phase <= stall_phase + 1;
        if (stall_phase % 97 == 0)
            stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // floor(a*b / 2^16) clamped to +-2^62, the magnitude of b held below 2^32
    function automatic longint q_mul(longint a, longint b);
        logic signed [127:0] p;
        longint              bc;
        bc = b;
        if (bc > DOT_CAP)
            bc = DOT_CAP;
        else if (bc < -DOT_CAP)
            bc = -DOT_CAP;
        p = $signed({{64{a[63]}}, a}) * $signed({{64{bc[63]}}, bc});
        p = p >>> 16;
        if (p > WIDE_CAP)
            p = WIDE_CAP;
        else if (p < -WIDE_CAP)
            p = -WIDE_CAP;
        return p[63:0];
    endfunction

    // order in use, with out-of-range settings folded in
    function automatic int order_now();
        if (order_reg == 0)
            return 1;
        if (order_reg > ORDER)
            return ORDER;
        return int'(order_reg);
    endfunction

    // address of the stored entry that stands for (i,j)
    function automatic int stored_addr(int i, int j);
        bit swap;
        swap = upper_reg ? (i > j) : (i < j);
        return swap ? (j * ORDER + i) : (i * ORDER + j);
    endfunction

    // y := beta*y + alpha*A*x, queue one expected entry per row
    task automatic predict_symv();
        int                 n;
        longint             dot;
        longint             t;
        logic signed [31:0] fresh [ORDER];
        bit                 clip [ORDER];
        y_entry_t           e;
        n = order_now();
        for (int i = 0; i < n; i++)
        begin
            dot = 0;
            for (int j = 0; j < n; j++)
                dot += q_mul(longint'(mat_mem[stored_addr(i, j)]), longint'(x_mem[j]));
            t = q_mul(longint'(beta_reg), longint'(y_mem[i])) + q_mul(longint'(alpha_reg), dot);
            clip[i] = 1'b0;
            if (t > 64'sd2147483647)
            begin
                t = 64'sd2147483647;
                clip[i] = 1'b1;
            end
            else if (t < -64'sd2147483648)
            begin
                t = -64'sd2147483648;
                clip[i] = 1'b1;
            end
            fresh[i] = t[31:0];
        end
        for (int i = 0; i < n; i++)
        begin
            y_mem[i]  = fresh[i];
            y_set[i]  = 1'b1;
            e.index   = i[3:0];
            e.result  = fresh[i];
            e.last    = (i == n - 1);
            e.sat     = clip[i];
            pending_y.push_back(e);
        end
    endtask

    // one request on the input stream; the shadow follows on acceptance
    task automatic send_request(action_t act, logic [3:0] row, logic [3:0] col,
                                logic [31:0] value);
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {value, col, row};
        do
            @(posedge clk);
        while (!s_tready);
        case (act)
            ACT_MAT:
            begin
                mat_mem[row * ORDER + col] = value;
                mat_set[row * ORDER + col] = 1'b1;
            end
            ACT_X:
            begin
                x_mem[row] = value;
                x_set[row] = 1'b1;
            end
            ACT_Y:
            begin
                y_mem[row] = value;
                y_set[row] = 1'b1;
            end
            default:
                predict_symv();
        endcase
        if (act == ACT_COMPUTE)
            computes_sent++;
        else
            loads_sent++;
        // bursts with random gaps between them
        burst_left--;
        if (burst_left <= 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 12);
        end
    endtask

    // write one register, only while the block is idle
    task automatic write_reg(cfg_idx_t idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_SIZE:  order_reg = data[4:0];
            CFG_UPPER: upper_reg = data[0];
            CFG_ALPHA: alpha_reg = data;
            default:   beta_reg  = data;
        endcase
    endtask

    // hold the sender until every result is back and the pipe is empty
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_y.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // mostly modest Q16.16 values, sometimes full range or extremes
    function automatic logic [31:0] rand_q();
        case ($urandom_range(0, 9))
            0:       return $urandom();
            1:       return ($urandom_range(0, 1) != 0) ? 32'h7fff_ffff : 32'h8000_0000;
            default: return $urandom_range(0, 8 * 65536) - 4 * 65536;
        endcase
    endfunction

    function automatic logic [31:0] rand_gain();
        case ($urandom_range(0, 7))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return ONE;
            4:       return $urandom();
            default: return $urandom_range(0, 4 * 65536) - 2 * 65536;
        endcase
    endfunction

    function automatic logic [31:0] rand_order();
        case ($urandom_range(0, 14))
            0:       return 0;
            1:       return 16;
            2:       return 17;
            3:       return 31;
            4:       return $urandom_range(5, 15);
            default: return $urandom_range(1, 4);
        endcase
    endfunction

    // a few stray loads, then whatever the next compute reads, then compute
    task automatic symv_sequence();
        int n;
        int a;
        repeat ($urandom_range(0, 6))
            send_request(action_t'($urandom_range(0, 2)), 4'($urandom_range(0, 15)),
                         4'($urandom_range(0, 15)), rand_q());
        n = order_now();
        for (int i = 0; i < n; i++)
        begin
            for (int j = 0; j < n; j++)
            begin
                a = stored_addr(i, j);
                if (!mat_set[a])
                    send_request(ACT_MAT, 4'(a / ORDER), 4'(a % ORDER), rand_q());
            end
            if (!x_set[i])
                send_request(ACT_X, 4'(i), 4'($urandom_range(0, 15)), rand_q());
            if (!y_set[i])
                send_request(ACT_Y, 4'(i), 4'($urandom_range(0, 15)), rand_q());
        end
        send_request(ACT_COMPUTE, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                     $urandom());
    endtask

    // result checker
    always @(posedge clk)
    begin
        y_entry_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (m_tuser[0])
                saturated_seen++;
            if (pending_y.size() == 0)
            begin
                $error("result with nothing expected: index %0d", m_tdata[3:0]);
                errors++;
            end
            else
            begin
                e = pending_y.pop_front();
                if (m_tdata[3:0] !== e.index)
                begin
                    $error("index: expected %0d, got %0d", e.index, m_tdata[3:0]);
                    errors++;
                end
                if (m_tdata[35:4] !== e.result)
                begin
                    $error("result: expected %h, got %h", e.result, m_tdata[35:4]);
                    errors++;
                end
                if (m_tlast !== e.last)
                begin
                    $error("last: expected %0d, got %0d", e.last, m_tlast);
                    errors++;
                end
                if (m_tuser[0] !== e.sat)
                begin
                    $error("saturated: expected %0d, got %0d", e.sat, m_tuser[0]);
                    errors++;
                end
            end
        end
    end

    // directed table, run at reset settings (order 1, lower, unit gains)
    directed_req_t directed [] = '{
        '{ACT_MAT,     4'd0,  4'd0,  ONE,          1'b0, 32'h0,         1'b0},
        '{ACT_X,       4'd0,  4'd0,  ONE,          1'b0, 32'h0,         1'b0},
        '{ACT_Y,       4'd0,  4'd0,  32'h0,        1'b0, 32'h0,         1'b0},
        '{ACT_COMPUTE, 4'd0,  4'd0,  32'h0,        1'b1, 32'h0001_0000, 1'b0},
        '{ACT_MAT,     4'd0,  4'd0,  32'h7fff_ffff, 1'b0, 32'h0,        1'b0},
        '{ACT_X,       4'd0,  4'd0,  32'h7fff_ffff, 1'b0, 32'h0,        1'b0},
        '{ACT_Y,       4'd0,  4'd0,  32'h7fff_ffff, 1'b0, 32'h0,        1'b0},
        '{ACT_COMPUTE, 4'd15, 4'd15, 32'hffff_ffff, 1'b1, 32'h7fff_ffff, 1'b1},
        '{ACT_MAT,     4'd0,  4'd0,  32'h8000_0000, 1'b0, 32'h0,        1'b0},
        '{ACT_Y,       4'd0,  4'd0,  32'h8000_0000, 1'b0, 32'h0,        1'b0},
        '{ACT_COMPUTE, 4'd0,  4'd0,  32'h0,        1'b1, 32'h8000_0000, 1'b1},
        '{ACT_MAT,     4'd0,  4'd0,  32'h0,        1'b0, 32'h0,         1'b0},
        '{ACT_Y,       4'd0,  4'd0,  32'hffff_ffff, 1'b0, 32'h0,        1'b0},
        '{ACT_COMPUTE, 4'd0,  4'd0,  32'h0,        1'b1, 32'hffff_ffff, 1'b0},
        '{ACT_MAT,     4'd15, 4'd15, 32'h5555_5555, 1'b0, 32'h0,        1'b0},
        '{ACT_MAT,     4'd15, 4'd0,  32'haaaa_aaaa, 1'b0, 32'h0,        1'b0},
        '{ACT_MAT,     4'd0,  4'd15, 32'h5555_5555, 1'b0, 32'h0,        1'b0},
        '{ACT_X,       4'd15, 4'd10, 32'haaaa_aaaa, 1'b0, 32'h0,        1'b0},
        '{ACT_Y,       4'd15, 4'd5,  32'h5555_5555, 1'b0, 32'h0,        1'b0},
        '{ACT_X,       4'd0,  4'd0,  32'h0002_8000, 1'b0, 32'h0,        1'b0},
        '{ACT_MAT,     4'd0,  4'd0,  32'hfffe_0000, 1'b0, 32'h0,        1'b0},
        // y0 is -2^-16 (one LSB) from the last compute; A*x = -2.0 * 2.5
        '{ACT_COMPUTE, 4'd0,  4'd0,  32'h0,        1'b1, 32'hfffa_ffff, 1'b0}
    };

    initial
    begin
        int phase;
        int random_reqs;
        int sent_mark;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        m_tready   = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        rst_n      = 1'b0;
        cycles     = 0;
        stall_mode = 0;
        stall_phase = 0;
        errors     = 0;
        burst_left = 4;
        order_reg  = 5'd1;
        upper_reg  = 1'b0;
        alpha_reg  = ONE;
        beta_reg   = ONE;
        for (int k = 0; k < ORDER * ORDER; k++)
        begin
            mat_mem[k] = '0;
            mat_set[k] = 1'b0;
        end
        for (int k = 0; k < ORDER; k++)
        begin
            x_mem[k] = '0;
            y_mem[k] = '0;
            x_set[k] = 1'b0;
            y_set[k] = 1'b0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part: typed results replace the predicted ones
        foreach (directed[k])
        begin
            send_request(directed[k].act, directed[k].row, directed[k].col, directed[k].value);
            if (directed[k].chk)
            begin
                pending_y[pending_y.size() - 1].result = directed[k].exp_result;
                pending_y[pending_y.size() - 1].sat    = directed[k].exp_sat;
            end
        end

        // random part: reconfigure while idle, then a few sequences
        random_reqs = 0;
        phase       = 0;
        while (random_reqs < RANDOM_REQS)
        begin
            drain();
            if (phase == 0)
            begin
                // out-of-range order and extreme gains first
                write_reg(CFG_SIZE, 32'd0);
                write_reg(CFG_UPPER, 32'd1);
                write_reg(CFG_ALPHA, 32'h8000_0000);
                write_reg(CFG_BETA, 32'h7fff_ffff);
            end
            else
            begin
                if ($urandom_range(0, 1) != 0)
                    write_reg(CFG_SIZE, rand_order());
                if ($urandom_range(0, 2) == 0)
                    write_reg(CFG_UPPER, $urandom_range(0, 1));
                if ($urandom_range(0, 1) != 0)
                    write_reg(CFG_ALPHA, rand_gain());
                if ($urandom_range(0, 1) != 0)
                    write_reg(CFG_BETA, rand_gain());
            end
            repeat ($urandom_range(1, 4))
            begin
                sent_mark = loads_sent + computes_sent;
                symv_sequence();
                random_reqs += loads_sent + computes_sent - sent_mark;
            end
            phase++;
        end

        drain();
        $display("covered %0d loads and %0d computes over %0d register phases",
                 loads_sent, computes_sent, phase);
        $display("checked %0d result entries, %0d of them saturated",
                 results_seen, saturated_seen);
        if (errors == 0 && pending_y.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
